@@ rtl/core/cbor_hp_pkg.sv @@
// shared types and codes of the cbor head and text parser
package cbor_hp_pkg;

    // result kinds
    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_INT  = 2'd1;
    localparam logic [1:0] KIND_TEXT = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_STATE = 2'd1;
    localparam logic [1:0] ERR_UNSUP = 2'd2;
    localparam logic [1:0] ERR_PARAM = 2'd3;

    // major types handled
    localparam logic [2:0] MAJ_UINT = 3'd0;
    localparam logic [2:0] MAJ_NINT = 3'd1;
    localparam logic [2:0] MAJ_TEXT = 3'd3;

    // short count codes
    localparam logic [4:0] SC_EXT_FIRST = 5'd24;
    localparam logic [4:0] SC_EXT_LAST  = 5'd27;
    localparam logic [4:0] SC_INDEF     = 5'd31;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        item_start;
        logic [31:0] total_bytes;
        logic        chunk_end;
    } beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  major_kind;
        logic [63:0] arg_value;
        logic [7:0]  text_byte;
        logic [1:0]  error_code;
        logic        chunk_ack;
    } result_t;

    // step request from the step control and answer from the decoder
    typedef struct packed {
        logic fire;
        logic has_result;
    } step_ctl_t;

endpackage

@@ rtl/core/cbor_hp_in_reg.sv @@
// input register stage of the cbor head and text parser
module cbor_hp_in_reg
    import cbor_hp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  beat_t s_beat,
    input  logic  step_fire,
    output logic  beat_valid,
    output beat_t beat
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    // a held beat leaves the stage when the decoder takes it
    assign s_ready    = !valid_reg || step_fire;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !step_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

@@ rtl/core/cbor_hp_decode.sv @@
// head, argument and text decoder with its item state
module cbor_hp_decode
    import cbor_hp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_fire,
    input  beat_t   beat,
    output logic    has_result,
    output result_t result
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_EXT  = 3'd1;
    localparam logic [2:0] PH_TEXT = 3'd2;
    localparam logic [2:0] PH_DONE = 3'd3;
    localparam logic [2:0] PH_ERR  = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  major_reg, major_next;
    logic [3:0]  ext_reg, ext_next;
    logic [63:0] accum_reg, accum_next;
    logic [31:0] left_reg, left_next;

    logic [4:0]  short_cnt;
    logic        fin;
    logic        fail;
    logic [1:0]  fail_code;

    assign short_cnt = beat.data_byte[4:0];

    always_comb begin
        phase_next = phase_reg;
        major_next = major_reg;
        ext_next   = ext_reg;
        accum_next = accum_reg;
        left_next  = left_reg;
        has_result = 1'b0;
        result     = '0;
        fin        = 1'b0;
        fail       = 1'b0;
        fail_code  = ERR_NONE;

        if (beat.item_start) begin
            major_next = beat.data_byte[7:5];
            accum_next = '0;
            ext_next   = '0;
            if (beat.total_bytes == 32'd0) begin
                left_next = '0;
                fail      = 1'b1;
                fail_code = ERR_STATE;
            end else begin
                left_next = beat.total_bytes - 32'd1;
                if (short_cnt == SC_INDEF) begin
                    fail      = 1'b1;
                    fail_code = ERR_UNSUP;
                end else if (short_cnt > SC_EXT_LAST) begin
                    fail      = 1'b1;
                    fail_code = ERR_PARAM;
                end else if (short_cnt < SC_EXT_FIRST) begin
                    accum_next = {59'd0, short_cnt};
                    fin        = 1'b1;
                end else begin
                    // 1, 2, 4 or 8 argument bytes follow
                    ext_next   = 4'd1 << short_cnt[1:0];
                    phase_next = PH_EXT;
                    has_result = beat.chunk_end;
                    result.kind = KIND_ACK;
                end
            end
        end else begin
            unique case (phase_reg)
                PH_EXT: begin
                    if (left_reg == 32'd0) begin
                        fail      = 1'b1;
                        fail_code = ERR_STATE;
                    end else begin
                        left_next  = left_reg - 32'd1;
                        accum_next = {accum_reg[55:0], beat.data_byte};
                        ext_next   = ext_reg - 4'd1;
                        if (ext_next == 4'd0) begin
                            fin = 1'b1;
                        end else begin
                            has_result  = beat.chunk_end;
                            result.kind = KIND_ACK;
                        end
                    end
                end
                PH_TEXT: begin
                    if (left_reg == 32'd0) begin
                        fail      = 1'b1;
                        fail_code = ERR_STATE;
                    end else begin
                        left_next = left_reg - 32'd1;
                        if (left_next == 32'd0) begin
                            phase_next = PH_DONE;
                        end
                        has_result       = 1'b1;
                        result.kind      = KIND_TEXT;
                        result.text_byte = beat.data_byte;
                    end
                end
                PH_DONE: begin
                    fail      = 1'b1;
                    fail_code = (major_reg == MAJ_UINT || major_reg == MAJ_NINT) ?
                                ERR_UNSUP : ERR_STATE;
                end
                PH_ERR: begin
                    has_result = 1'b0;
                end
                default: begin
                    fail      = 1'b1;
                    fail_code = ERR_STATE;
                end
            endcase
        end

        // argument complete: type checks
        if (fin) begin
            ext_next = '0;
            if (major_next == MAJ_UINT || major_next == MAJ_NINT) begin
                if (left_next != 32'd0) begin
                    fail      = 1'b1;
                    fail_code = ERR_STATE;
                end else begin
                    phase_next       = PH_DONE;
                    has_result       = 1'b1;
                    result.kind      = KIND_INT;
                    result.arg_value = accum_next;
                end
            end else if (major_next == MAJ_TEXT) begin
                if ({32'd0, left_next} != accum_next) begin
                    fail      = 1'b1;
                    fail_code = ERR_STATE;
                end else begin
                    phase_next  = (left_next == 32'd0) ? PH_DONE : PH_TEXT;
                    has_result  = beat.chunk_end;
                    result.kind = KIND_ACK;
                end
            end else begin
                fail      = 1'b1;
                fail_code = ERR_UNSUP;
            end
        end

        if (fail) begin
            phase_next        = PH_ERR;
            has_result        = 1'b1;
            result.kind       = KIND_ERR;
            result.arg_value  = '0;
            result.text_byte  = '0;
            result.error_code = fail_code;
        end

        result.major_kind = major_next;
        result.chunk_ack  = beat.chunk_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            major_reg <= '0;
            ext_reg   <= '0;
            accum_reg <= '0;
            left_reg  <= '0;
        end else if (step_fire) begin
            phase_reg <= phase_next;
            major_reg <= major_next;
            ext_reg   <= ext_next;
            accum_reg <= accum_next;
            left_reg  <= left_next;
        end
    end

endmodule

@@ rtl/core/cbor_hp_out_reg.sv @@
// result register of the cbor head and text parser
module cbor_hp_out_reg
    import cbor_hp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  step_ctl_t ctl,
    input  result_t   result,
    output logic      out_free,
    output logic      m_valid,
    input  logic      m_ready,
    output result_t   m_result
);

    logic    valid_reg;
    logic    valid_next;
    logic    load;
    result_t result_reg;

    assign out_free   = !valid_reg || m_ready;
    assign load       = ctl.fire && ctl.has_result;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

@@ rtl/core/cbor_hp_parser.sv @@
// step control: decides when the held beat is decoded
module cbor_hp_parser
    import cbor_hp_pkg::*;
(
    input  logic      beat_valid,
    input  logic      has_result,
    input  logic      out_free,
    output step_ctl_t ctl
);

    // a beat that gives no result never waits on the result register
    assign ctl.fire       = beat_valid && (out_free || !has_result);
    assign ctl.has_result = has_result;

endmodule

@@ rtl/core/cbor_head_and_text_parser.sv @@
// top level of the cbor head and text parser
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_valid / s_ready  | data_byte, item_start, total_bytes, chunk_end
//  m_      | out | m_valid / m_ready  | kind, major_kind, arg_value, text_byte,
//          |     |                    | error_code, chunk_ack
//
//  one beat per cycle while the result register is free or the beat gives no result;
//  a beat is decoded from the input register and its result registered toward m_
//  the decode step (argument shift, remaining-length count and compare) is the
//  only logic between the input register and the result register
//  aresetn is synchronous and active low; it clears the item state to idle and
//  empties both registers
//  a stalled m_ side holds the result; the input register keeps taking beats
//  while the held beat gives no result, and fills behind a full result register
module cbor_head_and_text_parser
    import cbor_hp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_item_start,
    input  logic [31:0] s_total_bytes,
    input  logic        s_chunk_end,
    // result beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [2:0]  m_major_kind,
    output logic [63:0] m_arg_value,
    output logic [7:0]  m_text_byte,
    output logic [1:0]  m_error_code,
    output logic        m_chunk_ack
);

    beat_t     s_beat;
    beat_t     beat;
    logic      beat_valid;
    logic      has_result;
    logic      out_free;
    step_ctl_t ctl;
    result_t   result;
    result_t   m_result;

    // gather the input ports into one beat
    assign s_beat.data_byte   = s_data_byte;
    assign s_beat.item_start  = s_item_start;
    assign s_beat.total_bytes = s_total_bytes;
    assign s_beat.chunk_end   = s_chunk_end;

    // input register: takes a new beat whenever it is empty or the held one moves on
    cbor_hp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .step_fire  (ctl.fire),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    // item state and the per-beat decode step
    cbor_hp_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_fire  (ctl.fire),
        .beat       (beat),
        .has_result (has_result),
        .result     (result)
    );

    // step control between the two registers
    cbor_hp_parser u_ctl (
        .beat_valid (beat_valid),
        .has_result (has_result),
        .out_free   (out_free),
        .ctl        (ctl)
    );

    // result register toward m_
    cbor_hp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // spread the result onto its ports
    assign m_kind       = m_result.kind;
    assign m_major_kind = m_result.major_kind;
    assign m_arg_value  = m_result.arg_value;
    assign m_text_byte  = m_result.text_byte;
    assign m_error_code = m_result.error_code;
    assign m_chunk_ack  = m_result.chunk_ack;

endmodule

@@ rtl/core/cbor_hp_checker.sv @@
// port-level checker of the cbor head and text parser and its bind
module cbor_hp_checker
    import cbor_hp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [63:0] m_arg_value,
    input logic [7:0]  m_text_byte,
    input logic [1:0]  m_error_code,
    input logic        m_chunk_ack
);

    // a stalled result beat stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_arg_value))
        else $error("result beat changed while stalled");

    // error code present exactly on error beats
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_kind == KIND_ERR) == (m_error_code != ERR_NONE)))
        else $error("error code does not match result kind");

    // argument only on integer beats, text byte only on text beats
    a_arg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_INT |-> m_arg_value == 64'd0)
        else $error("argument on a non-integer beat");

    a_text: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_TEXT |-> m_text_byte == 8'd0)
        else $error("text byte on a non-text beat");

    // a bare acknowledge only closes a chunk
    a_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ACK |-> m_chunk_ack)
        else $error("acknowledge beat without chunk end");

endmodule

bind cbor_head_and_text_parser cbor_hp_checker u_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_arg_value  (m_arg_value),
    .m_text_byte  (m_text_byte),
    .m_error_code (m_error_code),
    .m_chunk_ack  (m_chunk_ack)
);
